### src/teq_pkg.sv
// ----------------------------------------------------------------------------
// Timer expiry queue package
// Shared widths, codes and the request/result structures.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned Timers   = 16;
  localparam int unsigned SlotW    = $clog2(Timers);
  localparam int unsigned TimeW    = 48;
  localparam int unsigned IvW      = 32;
  localparam int unsigned NextW    = 31;
  localparam int unsigned HandleW  = 4;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;
  localparam logic [1:0] OpPoll   = 2'd2;

  localparam logic [1:0] KindAdd    = 2'd0;
  localparam logic [1:0] KindCancel = 2'd1;
  localparam logic [1:0] KindExpire = 2'd2;
  localparam logic [1:0] KindDone   = 2'd3;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StNoSuch = 2'd2;

  localparam logic [NextW-1:0] NextCap = {NextW{1'b1}};

  typedef struct packed {
    logic [1:0]         kind;
    logic [HandleW-1:0] handle_res;
    logic [1:0]         status;
    logic [NextW-1:0]   next_timeout_ms;
    logic               last;
  } result_t;

  // Compare unit request and answer.
  typedef struct packed {
    logic [TimeW-1:0] a;
    logic [TimeW-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic             lt;
    logic             le;
    logic [TimeW-1:0] diff;
  } cmp_rsp_t;

endpackage

### src/teq_cmp.sv
// ----------------------------------------------------------------------------
// Timer expiry queue compare unit
// One shared subtractor giving a - b with less-than and less-or-equal flags.
// ----------------------------------------------------------------------------
module teq_cmp (
  input  teq_pkg::cmp_req_t req_i,
  output teq_pkg::cmp_rsp_t rsp_o
);

  logic [teq_pkg::TimeW:0] sub;

  assign sub = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.lt   = sub[teq_pkg::TimeW];
  assign rsp_o.le   = sub[teq_pkg::TimeW] || (req_i.a == req_i.b);
  assign rsp_o.diff = sub[teq_pkg::TimeW-1:0];

endmodule

### src/timer_expiry_queue_top.sv
// ----------------------------------------------------------------------------
// Timer expiry queue
// Sixteen timer slots with add, cancel and ordered poll.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel; results leave on m_axis, tlast
// marking the final result of each request. One request is handled at a
// time and s_axis_tready stays low until its last result has been taken.
// An add checks one slot per cycle and takes the lowest free slot, or
// reports the table full when none is free. A cancel passes through
// S_CANCEL before S_OUT; an undefined op goes straight to S_OUT.
// A poll makes one pass through the shared compare unit for each expired
// timer it reports, then one more pass and a pass to find the nearest
// expiry. The next request can be taken in the cycle after the last
// result handshake. The result register holds while m_axis_tready is low
// and the sequencer waits. After reset all slots are free; interval and
// expiry storage is not cleared since it is only read for live slots.
// ----------------------------------------------------------------------------
module timer_expiry_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], now_ms[49:2], interval_ms[81:50], periodic[82], handle[86:83]
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kind[1:0], handle_res[5:2], status[7:6], next_timeout_ms[38:8]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned SlotW = teq_pkg::SlotW;
  localparam int unsigned TimeW = teq_pkg::TimeW;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_CANCEL, S_SCAN, S_NEXT, S_OUT
  } state_e;

  state_e                   state_q;
  logic [TimeW-1:0]         now_q;
  logic [teq_pkg::IvW-1:0]  iv_q;
  logic                     per_q;
  logic [3:0]               handle_q;
  logic [SlotW:0]           idx_q;
  logic                     found_q;
  logic [SlotW-1:0]         pick_q;
  logic [TimeW-1:0]         best_q;
  logic [teq_pkg::Timers-1:0] valid_q, periodic_q, done_q;
  logic [teq_pkg::IvW-1:0]  interval_q [teq_pkg::Timers];
  logic [TimeW-1:0]         expiry_q   [teq_pkg::Timers];
  teq_pkg::result_t         res_q;
  logic                     res_v_q;
  logic                     out_last_q;
  state_e                   after_q;

  teq_pkg::cmp_req_t creq;
  teq_pkg::cmp_rsp_t crsp;
  logic [SlotW-1:0]  idx;
  logic [TimeW:0]    sum;
  logic [TimeW-1:0]  sat_exp;
  logic [teq_pkg::IvW-1:0] rearm_iv;

  assign idx = idx_q[SlotW-1:0];

  teq_cmp u_cmp (.req_i(creq), .rsp_o(crsp));

  // During scans compare current slot expiry against the best so far, or,
  // in the expiry scan, against now before any candidate is found. The final
  // step of the nearest-expiry pass compares the best expiry against now.
  always_comb begin
    creq.a = expiry_q[idx];
    creq.b = best_q;
    if (state_q == S_SCAN && !found_q) creq.b = now_q;
    if (state_q == S_NEXT && idx_q == (SlotW+1)'(teq_pkg::Timers)) begin
      creq.a = best_q;
      creq.b = now_q;
    end
  end

  assign rearm_iv = (state_q == S_ADD) ? iv_q : interval_q[pick_q];
  assign sum      = {1'b0, now_q} + {{(TimeW - teq_pkg::IvW + 1){1'b0}}, rearm_iv};
  assign sat_exp  = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = {1'b0, res_q.next_timeout_ms, res_q.status,
                          res_q.handle_res, res_q.kind};
  assign m_axis_tlast  = res_q.last;

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADD && idx_q < (SlotW+1)'(teq_pkg::Timers) && !valid_q[idx]) begin
      interval_q[idx] <= iv_q;
      expiry_q[idx]   <= sat_exp;
    end
    if (state_q == S_SCAN && idx_q == (SlotW+1)'(teq_pkg::Timers) && found_q &&
        periodic_q[pick_q]) begin
      expiry_q[pick_q] <= sat_exp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      after_q    <= S_IDLE;
      valid_q    <= '0;
      periodic_q <= '0;
      done_q     <= '0;
      res_v_q    <= 1'b0;
      idx_q      <= '0;
      found_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            now_q    <= s_axis_tdata[49:2];
            iv_q     <= s_axis_tdata[81:50];
            per_q    <= s_axis_tdata[82];
            handle_q <= s_axis_tdata[86:83];
            idx_q    <= '0;
            found_q  <= 1'b0;
            done_q   <= '0;
            case (s_axis_tdata[1:0])
              teq_pkg::OpAdd:    state_q <= S_ADD;
              teq_pkg::OpCancel: state_q <= S_CANCEL;
              teq_pkg::OpPoll:   state_q <= S_SCAN;
              default: begin
                res_q   <= '{teq_pkg::KindAdd, '0, teq_pkg::StOk, '0, 1'b1};
                state_q <= S_OUT;
                after_q <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD: begin
          after_q <= S_IDLE;
          if (idx_q == (SlotW+1)'(teq_pkg::Timers)) begin
            res_q   <= '{teq_pkg::KindAdd, '0, teq_pkg::StFull, '0, 1'b1};
            state_q <= S_OUT;
          end else if (!valid_q[idx]) begin
            valid_q[idx]    <= 1'b1;
            periodic_q[idx] <= per_q;
            res_q   <= '{teq_pkg::KindAdd, teq_pkg::HandleW'(idx), teq_pkg::StOk, '0, 1'b1};
            state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_CANCEL: begin
          after_q <= S_IDLE;
          state_q <= S_OUT;
          if ({4'b0, handle_q} < 8'(teq_pkg::Timers) &&
              valid_q[handle_q[SlotW-1:0]]) begin
            valid_q[handle_q[SlotW-1:0]]    <= 1'b0;
            periodic_q[handle_q[SlotW-1:0]] <= 1'b0;
            res_q <= '{teq_pkg::KindCancel, handle_q, teq_pkg::StOk, '0, 1'b1};
          end else begin
            res_q <= '{teq_pkg::KindCancel, '0, teq_pkg::StNoSuch, '0, 1'b1};
          end
        end
        S_SCAN: begin
          if (idx_q == (SlotW+1)'(teq_pkg::Timers)) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            if (found_q) begin
              done_q[pick_q] <= 1'b1;
              if (!periodic_q[pick_q]) valid_q[pick_q] <= 1'b0;
              res_q   <= '{teq_pkg::KindExpire, teq_pkg::HandleW'(pick_q),
                           teq_pkg::StOk, '0, 1'b0};
              state_q <= S_OUT;
              after_q <= S_SCAN;
            end else begin
              state_q <= S_NEXT;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            if (valid_q[idx] && !done_q[idx] && (found_q ? crsp.lt : crsp.le)) begin
              found_q <= 1'b1;
              pick_q  <= idx;
              best_q  <= expiry_q[idx];
            end
          end
        end
        S_NEXT: begin
          if (idx_q == (SlotW+1)'(teq_pkg::Timers)) begin
            res_q.kind       <= teq_pkg::KindDone;
            res_q.handle_res <= '0;
            res_q.status     <= teq_pkg::StOk;
            res_q.last       <= 1'b1;
            if (!found_q) res_q.next_timeout_ms <= teq_pkg::NextCap;
            else if (crsp.le) res_q.next_timeout_ms <= '0;
            else if (|crsp.diff[TimeW-1:teq_pkg::NextW])
              res_q.next_timeout_ms <= teq_pkg::NextCap;
            else res_q.next_timeout_ms <= crsp.diff[teq_pkg::NextW-1:0];
            state_q <= S_OUT;
            after_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
            if (valid_q[idx] && (!found_q || crsp.lt)) begin
              found_q <= 1'b1;
              best_q  <= expiry_q[idx];
            end
          end
        end
        S_OUT: begin
          if (!res_v_q) begin
            res_v_q    <= 1'b1;
            out_last_q <= res_q.last;
          end else if (m_axis_tready) begin
            res_v_q <= 1'b0;
            state_q <= after_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_last_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == out_last_q)) else $error("last mismatch");
  a_expire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == teq_pkg::KindExpire) |-> !m_axis_tlast)
    else $error("expiry marked last");

endmodule
